// ===== design/torls_pkg.sv =====
// torls_pkg: shared types and constants for the telnet option refuser / line splitter
// holds result kinds, queue operation codes, telnet byte codes and the queue entry type
// no dependencies
package torls_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EOL   = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_EOL   = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [7:0] len;
    logic       ovf;
    logic       verb_dont;
  } entry_t;

endpackage

// ===== design/telnet_option_refuser_line_splitter_unit.sv =====
// telnet_option_refuser_line_splitter_unit: top level, parser -> queue -> result generator
// depends on torls_pkg, torls_front, torls_queue, torls_back
// an accepted byte's entry is written into the queue register, then loaded into the back end's output register
// throughput: one input byte per cycle while the queue is not full; a negotiation reply becomes three result words
// input stalls only while the two-entry queue is full
// reset: synchronous active-low rst_n clears parse state, line count, queue and output valid
module telnet_option_refuser_line_splitter_unit #(
  parameter int LINE_MAX = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic [7:0] out_line_length,
  output logic       out_overflow,
  output logic       out_last
);

  logic              push;
  torls_pkg::entry_t push_entry;
  logic              pop;
  logic              full;
  logic              head_valid;
  torls_pkg::entry_t head;

  assign in_stall = full;

  torls_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .q_full     (full),
    .rx_byte    (in_rx_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  torls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  torls_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_line_length (out_line_length),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

endmodule

// ===== design/torls_front.sv =====
// torls_front: parses telnet bytes, tracks the line counter, emits work entries
// depends on torls_pkg
module torls_front #(
  parameter int LINE_MAX = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              q_full,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output torls_pkg::entry_t push_entry
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int LW = (CW > 8) ? CW : 8;

  localparam logic [2:0] PS_NORMAL = 3'd0;
  localparam logic [2:0] PS_IAC    = 3'd1;
  localparam logic [2:0] PS_WILL   = 3'd2;
  localparam logic [2:0] PS_WONT   = 3'd3;
  localparam logic [2:0] PS_DO     = 3'd4;
  localparam logic [2:0] PS_DONT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          acc;
  logic          is_data;
  logic [CW-1:0] cnt_inc;
  logic [LW-1:0] len_ext;
  logic [LW-1:0] inc_ext;
  logic [7:0]    len_sat;
  logic [7:0]    inc_sat;

  assign acc     = in_valid && !q_full;
  assign cnt_inc = cnt_r + CW'(1);
  assign len_ext = LW'(cnt_r);
  assign inc_ext = LW'(cnt_inc);
  assign len_sat = (len_ext > LW'(255)) ? 8'd255 : len_ext[7:0];
  assign inc_sat = (inc_ext > LW'(255)) ? 8'd255 : inc_ext[7:0];

  always_comb begin
    state_nxt  = PS_NORMAL;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    push       = 1'b0;
    is_data    = 1'b0;
    push_entry = '{op: torls_pkg::OP_CHAR, data: rx_byte, len: 8'd0, ovf: 1'b0,
                   verb_dont: 1'b0};
    unique case (state_r)
      PS_IAC: begin
        priority if (rx_byte == torls_pkg::B_IAC) is_data = 1'b1;
        else if (rx_byte == torls_pkg::B_WILL) state_nxt = PS_WILL;
        else if (rx_byte == torls_pkg::B_WONT) state_nxt = PS_WONT;
        else if (rx_byte == torls_pkg::B_DO) state_nxt = PS_DO;
        else if (rx_byte == torls_pkg::B_DONT) state_nxt = PS_DONT;
        else state_nxt = PS_NORMAL;
      end
      PS_WILL, PS_WONT: begin
        push = 1'b1;
        push_entry.op = torls_pkg::OP_REPLY;
        push_entry.verb_dont = 1'b1;
      end
      PS_DO, PS_DONT: begin
        push = 1'b1;
        push_entry.op = torls_pkg::OP_REPLY;
      end
      default: begin
        if (rx_byte == torls_pkg::B_IAC) state_nxt = PS_IAC;
        else is_data = 1'b1;
      end
    endcase
    if (is_data) begin
      priority if (rx_byte == torls_pkg::B_CR) begin
        push = 1'b0;
      end else if (rx_byte == torls_pkg::B_LF) begin
        push = 1'b1;
        push_entry.op   = torls_pkg::OP_EOL;
        push_entry.data = 8'd0;
        push_entry.len  = len_sat;
        push_entry.ovf  = ovf_r;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (cnt_r >= CW'(LINE_MAX)) begin
        ovf_nxt = 1'b1;
      end else begin
        push = 1'b1;
        push_entry.len = inc_sat;
        push_entry.ovf = ovf_r;
        cnt_nxt = cnt_inc;
      end
    end
    if (!acc) push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_NORMAL;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (acc) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== design/torls_queue.sv =====
// torls_queue: two-entry queue between parser and result generator
// depends on torls_pkg
module torls_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  torls_pkg::entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output torls_pkg::entry_t head
);

  torls_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/torls_back.sv =====
// torls_back: expands queued entries into result words and holds the output register
// depends on torls_pkg
module torls_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  torls_pkg::entry_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_out_byte,
  output logic [7:0]        out_line_length,
  output logic              out_overflow,
  output logic              out_last
);

  logic [1:0] phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [7:0] len_r, len_nxt;
  logic       ovf_r, ovf_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = head_valid && (!valid_r || !out_stall);

  always_comb begin
    phase_nxt = phase_r;
    pop       = 1'b0;
    valid_nxt = valid_r && out_stall;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (head.op == torls_pkg::OP_REPLY) begin
        kind_nxt = torls_pkg::KIND_REPLY;
        len_nxt  = 8'd0;
        ovf_nxt  = 1'b0;
        unique case (phase_r)
          2'd0: byte_nxt = torls_pkg::B_IAC;
          2'd1: byte_nxt = head.verb_dont ? torls_pkg::B_DONT : torls_pkg::B_WONT;
          default: byte_nxt = head.data;
        endcase
        last_nxt = (phase_r == 2'd2);
        if (phase_r == 2'd2) begin
          phase_nxt = 2'd0;
          pop       = 1'b1;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end else begin
        kind_nxt  = (head.op == torls_pkg::OP_EOL) ? torls_pkg::KIND_EOL
                                                   : torls_pkg::KIND_CHAR;
        byte_nxt  = head.data;
        len_nxt   = head.len;
        ovf_nxt   = head.ovf;
        last_nxt  = 1'b1;
        phase_nxt = 2'd0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    len_r  <= len_nxt;
    ovf_r  <= ovf_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_out_byte    = byte_r;
  assign out_line_length = len_r;
  assign out_overflow    = ovf_r;
  assign out_last        = last_r;

endmodule

// ===== design/torls_checker.sv =====
// torls_checker: port-level checks on the telnet refuser / line splitter result channel
// depends on torls_pkg; bound to telnet_option_refuser_line_splitter_unit
module torls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_out_byte,
  input logic [7:0] out_line_length,
  input logic       out_overflow,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_out_byte)
      && $stable(out_last))
    else $error("stalled result word changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == torls_pkg::KIND_CHAR || out_kind == torls_pkg::KIND_EOL
      || out_kind == torls_pkg::KIND_REPLY)
    else $error("illegal result kind");

  a_eol_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == torls_pkg::KIND_EOL |-> out_last && out_out_byte == 8'd0)
    else $error("end of line word malformed");

  a_char_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == torls_pkg::KIND_CHAR |-> out_last && out_line_length != 8'd0)
    else $error("character word malformed");

  a_reply_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == torls_pkg::KIND_REPLY |->
      out_line_length == 8'd0 && !out_overflow)
    else $error("reply word carries line info");

endmodule

bind telnet_option_refuser_line_splitter_unit torls_checker u_torls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_out_byte    (out_out_byte),
  .out_line_length (out_line_length),
  .out_overflow    (out_overflow),
  .out_last        (out_last)
);
